### rtl/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg
// Shared types and constants for the information frame receiver: the
// configuration bundle, the command word that passes from the front end to
// the back end, receive phases, reply positions and reply control codes.
// ----------------------------------------------------------------------------
package ifr_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned IFR_FIFO_DEPTH = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLAG_BYTE   = 3'd0,
    REG_ESCAPE_BYTE = 3'd1,
    REG_FLAG_SUBST  = 3'd2,
    REG_ESCAPE_SUBST = 3'd3,
    REG_CMD_ADDR    = 3'd4,
    REG_REPLY_ADDR  = 3'd5
  } cfg_reg_e;

  localparam logic [BYTE_W-1:0] RST_FLAG_BYTE    = 8'h7E;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] RST_FLAG_SUBST   = 8'h5E;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_SUBST = 8'h5D;
  localparam logic [BYTE_W-1:0] RST_CMD_ADDR     = 8'h03;
  localparam logic [BYTE_W-1:0] RST_REPLY_ADDR   = 8'h01;

  // Control byte of an information frame: only the sequence bit may be set.
  localparam logic [BYTE_W-1:0] CTRL_SEQ_BIT = 8'h40;

  // Reply control codes; bit 7 carries the sequence number wanted next.
  localparam logic [BYTE_W-1:0] CTRL_RR_SEQ0  = 8'h05;
  localparam logic [BYTE_W-1:0] CTRL_RR_SEQ1  = 8'h85;
  localparam logic [BYTE_W-1:0] CTRL_REJ_SEQ0 = 8'h01;
  localparam logic [BYTE_W-1:0] CTRL_REJ_SEQ1 = 8'h81;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] flag_subst;
    logic [BYTE_W-1:0] escape_subst;
    logic [BYTE_W-1:0] cmd_addr;
    logic [BYTE_W-1:0] reply_addr;
  } cfg_t;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_ACCEPT  = 2'd1,
    VERDICT_DISCARD = 2'd2,
    VERDICT_REJECT  = 2'd3
  } verdict_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPLY   = 1'b1
  } kind_e;

  // Receive phases of the front end, one-hot.
  typedef enum logic [4:0] {
    PH_WAIT = 5'b00001,
    PH_FLAG = 5'b00010,
    PH_ADDR = 5'b00100,
    PH_CTRL = 5'b01000,
    PH_DATA = 5'b10000
  } phase_e;

  // Byte positions inside a reply frame.
  localparam int unsigned REPLY_LEN = 5;
  localparam int unsigned POS_W     = $clog2(REPLY_LEN);

  typedef enum logic [POS_W-1:0] {
    POS_OPEN   = 3'd0,
    POS_ADDR   = 3'd1,
    POS_CTRL   = 3'd2,
    POS_PARITY = 3'd3,
    POS_CLOSE  = 3'd4
  } reply_pos_e;

  // One unit of work for the back end: a payload byte or a whole reply.
  // For a reply, data holds the reply control byte.
  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    verdict_e          verdict;
  } cmd_t;

endpackage

### rtl/info_frame_receiver.sv
// ----------------------------------------------------------------------------
// info_frame_receiver
// Receive side of a stop-and-wait framed link: one line byte per item in,
// destuffed payload bytes and five-byte acknowledgement replies out.
// ----------------------------------------------------------------------------
// Throughput: one line byte per cycle; full rises only when the command queue
// fills, behind replies that drain at one byte per cycle or a stalled result side.
// Path: a payload byte enters the command queue when the next data byte of its
// frame is taken, a reply with the closing flag; the back end then registers each.
// Reset: asynchronous; clears the receive state, sequence bits and queue, and
// loads the configuration defaults.
module info_frame_receiver #(
  parameter int unsigned FifoDepth = ifr_pkg::IFR_FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [ifr_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_kind_o,
  output logic [ifr_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          out_last_o,
  output logic [1:0]                    verdict_o,
  input  logic                          cfg_we_i,
  input  logic [ifr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ifr_pkg::BYTE_W-1:0]    cfg_wdata_i
);
  import ifr_pkg::*;

  cfg_t cfg_q;
  logic accept;
  logic cmd_valid;
  cmd_t cmd_wr;
  cmd_t cmd_rd;
  logic cmd_empty;
  logic cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte    <= RST_FLAG_BYTE;
      cfg_q.escape_byte  <= RST_ESCAPE_BYTE;
      cfg_q.flag_subst   <= RST_FLAG_SUBST;
      cfg_q.escape_subst <= RST_ESCAPE_SUBST;
      cfg_q.cmd_addr     <= RST_CMD_ADDR;
      cfg_q.reply_addr   <= RST_REPLY_ADDR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FLAG_BYTE:    cfg_q.flag_byte    <= cfg_wdata_i;
        REG_ESCAPE_BYTE:  cfg_q.escape_byte  <= cfg_wdata_i;
        REG_FLAG_SUBST:   cfg_q.flag_subst   <= cfg_wdata_i;
        REG_ESCAPE_SUBST: cfg_q.escape_subst <= cfg_wdata_i;
        REG_CMD_ADDR:     cfg_q.cmd_addr     <= cfg_wdata_i;
        REG_REPLY_ADDR:   cfg_q.reply_addr   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  ifr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_wr)
  );

  ifr_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_valid),
    .wr_data_i (cmd_wr),
    .full_o    (full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_rd),
    .empty_o   (cmd_empty)
  );

  ifr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .verdict_o   (verdict_o)
  );

endmodule

### rtl/ifr_fifo.sv
// ----------------------------------------------------------------------------
// ifr_fifo
// Small command queue between the front end and the back end, so that the
// line side keeps taking bytes while a reply drains.
// ----------------------------------------------------------------------------
module ifr_fifo #(
  parameter int unsigned Depth = ifr_pkg::IFR_FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  ifr_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output ifr_pkg::cmd_t rd_data_o,
  output logic          empty_o
);
  import ifr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/ifr_front.sv
// ----------------------------------------------------------------------------
// ifr_front
// Line-side front end: frame hunt, header checks, destuffing, running check
// and frame judgement. Each accepted byte yields at most one command.
// ----------------------------------------------------------------------------
module ifr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ifr_pkg::cfg_t             cfg_i,
  input  logic                      accept_i,
  input  logic [ifr_pkg::BYTE_W-1:0] rx_byte_i,
  output logic                      cmd_valid_o,
  output ifr_pkg::cmd_t             cmd_o
);
  import ifr_pkg::*;

  phase_e            phase_q, phase_d;
  logic              rseq_q, rseq_d;
  logic              exp_q, exp_d;
  logic [BYTE_W-1:0] check_q, check_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic              held_valid_q, held_valid_d;
  logic              esc_q, esc_d;
  logic              fault_q, fault_d;

  logic              good, same;
  logic              data_ok;
  logic [BYTE_W-1:0] data_val;
  logic [BYTE_W-1:0] hdr_parity;

  assign good = held_valid_q && !fault_q && !esc_q && (check_q == held_q);
  assign same = (rseq_q == exp_q);
  assign hdr_parity = cfg_i.cmd_addr ^ (rseq_q ? CTRL_SEQ_BIT : '0);

  always_comb begin
    phase_d      = phase_q;
    rseq_d       = rseq_q;
    exp_d        = exp_q;
    check_d      = check_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    esc_d        = esc_q;
    fault_d      = fault_q;
    data_ok      = 1'b0;
    data_val     = rx_byte_i;
    cmd_valid_o  = 1'b0;
    cmd_o        = '{kind: KIND_PAYLOAD, data: held_q, verdict: VERDICT_NONE};

    if (accept_i) begin
      unique case (phase_q)
        PH_FLAG: begin
          if (rx_byte_i == cfg_i.cmd_addr) begin
            phase_d = PH_ADDR;
          end else if (rx_byte_i != cfg_i.flag_byte) begin
            phase_d = PH_WAIT;
          end
        end
        PH_ADDR: begin
          if ((rx_byte_i & ~CTRL_SEQ_BIT) == '0) begin
            rseq_d  = |(rx_byte_i & CTRL_SEQ_BIT);
            phase_d = PH_CTRL;
          end else begin
            phase_d = (rx_byte_i == cfg_i.flag_byte) ? PH_FLAG : PH_WAIT;
          end
        end
        PH_CTRL: begin
          if (rx_byte_i == hdr_parity) begin
            phase_d      = PH_DATA;
            check_d      = '0;
            held_valid_d = 1'b0;
            held_d       = '0;
            esc_d        = 1'b0;
            fault_d      = 1'b0;
          end else begin
            phase_d = (rx_byte_i == cfg_i.flag_byte) ? PH_FLAG : PH_WAIT;
          end
        end
        PH_DATA: begin
          if (rx_byte_i == cfg_i.flag_byte) begin
            // Closing flag: judge the frame and queue one reply.
            cmd_valid_o  = 1'b1;
            cmd_o.kind   = KIND_REPLY;
            if (good && same) begin
              exp_d         = ~exp_q;
              cmd_o.verdict = VERDICT_ACCEPT;
              cmd_o.data    = exp_d ? CTRL_RR_SEQ1 : CTRL_RR_SEQ0;
            end else if (same) begin
              cmd_o.verdict = VERDICT_REJECT;
              cmd_o.data    = exp_q ? CTRL_REJ_SEQ1 : CTRL_REJ_SEQ0;
            end else begin
              cmd_o.verdict = VERDICT_DISCARD;
              cmd_o.data    = exp_q ? CTRL_RR_SEQ1 : CTRL_RR_SEQ0;
            end
            phase_d      = PH_FLAG;
            held_valid_d = 1'b0;
            esc_d        = 1'b0;
            fault_d      = 1'b0;
            check_d      = '0;
          end else begin
            if (esc_q) begin
              esc_d = 1'b0;
              if (rx_byte_i == cfg_i.flag_subst) begin
                data_val = cfg_i.flag_byte;
                data_ok  = 1'b1;
              end else if (rx_byte_i == cfg_i.escape_subst) begin
                data_val = cfg_i.escape_byte;
                data_ok  = 1'b1;
              end else begin
                fault_d = 1'b1;
              end
            end else if (rx_byte_i == cfg_i.escape_byte) begin
              esc_d = 1'b1;
            end else begin
              data_ok = 1'b1;
            end
            // The newest byte is held back; it may turn out to be the check byte.
            if (data_ok) begin
              held_d       = data_val;
              held_valid_d = 1'b1;
              if (held_valid_q) begin
                check_d     = check_q ^ held_q;
                cmd_valid_o = 1'b1;
              end
            end
          end
        end
        default: begin
          phase_d = (rx_byte_i == cfg_i.flag_byte) ? PH_FLAG : PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT;
      rseq_q       <= 1'b0;
      exp_q        <= 1'b0;
      check_q      <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      esc_q        <= 1'b0;
      fault_q      <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      rseq_q       <= rseq_d;
      exp_q        <= exp_d;
      check_q      <= check_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      esc_q        <= esc_d;
      fault_q      <= fault_d;
    end
  end

endmodule

### rtl/ifr_back.sv
// ----------------------------------------------------------------------------
// ifr_back
// Result-side back end: takes commands from the queue and presents results,
// one payload byte per command or the five bytes of a reply frame.
// ----------------------------------------------------------------------------
module ifr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ifr_pkg::cfg_t              cfg_i,
  input  logic                       cmd_empty_i,
  input  ifr_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic                       out_kind_o,
  output logic [ifr_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       out_last_o,
  output logic [1:0]                 verdict_o
);
  import ifr_pkg::*;

  cmd_t       cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  reply_pos_e pos_q, pos_d;
  logic       cur_last;
  logic       taken;

  assign cur_last  = (cur_q.kind == KIND_PAYLOAD) || (pos_q == POS_CLOSE);
  assign taken     = pop_i && cur_valid_q;
  assign cmd_pop_o = !cur_valid_q || (taken && cur_last);

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    pos_d       = pos_q;
    if (cmd_pop_o) begin
      cur_valid_d = !cmd_empty_i;
      cur_d       = cmd_i;
      pos_d       = POS_OPEN;
    end else if (taken) begin
      pos_d = reply_pos_e'(pos_q + POS_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= POS_OPEN;
    end else begin
      cur_valid_q <= cur_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    out_byte_o = cur_q.data;
    if (cur_q.kind == KIND_REPLY) begin
      unique case (pos_q)
        POS_OPEN:   out_byte_o = cfg_i.flag_byte;
        POS_ADDR:   out_byte_o = cfg_i.reply_addr;
        POS_CTRL:   out_byte_o = cur_q.data;
        POS_PARITY: out_byte_o = cfg_i.reply_addr ^ cur_q.data;
        POS_CLOSE:  out_byte_o = cfg_i.flag_byte;
        default:    out_byte_o = cur_q.data;
      endcase
    end
  end

  assign empty_o    = !cur_valid_q;
  assign out_kind_o = cur_q.kind;
  assign out_last_o = (cur_q.kind == KIND_REPLY) && (pos_q == POS_CLOSE);
  assign verdict_o  = cur_q.verdict;

endmodule

### rtl/ifr_checker.sv
// ----------------------------------------------------------------------------
// ifr_checker
// Port-level checks on the result side of the frame receiver, bound to the
// top level.
// ----------------------------------------------------------------------------
module ifr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       out_kind_o,
  input logic [7:0] out_byte_o,
  input logic       out_last_o,
  input logic [1:0] verdict_o
);

  // Only the closing byte of a reply is marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_last_o) |-> out_kind_o)
    else $error("last marker on a payload item");

  // Payload items carry no verdict; reply items always carry one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((out_kind_o == 1'b0) == (verdict_o == 2'd0)))
    else $error("verdict does not match item kind");

  // The five bytes of a reply come back to back with one verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_kind_o && !out_last_o)
      |=> (!empty && out_kind_o && $stable(verdict_o)))
    else $error("reply frame broken up");

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(out_last_o)))
    else $error("waiting item changed");

endmodule

bind info_frame_receiver ifr_checker u_ifr_checker (.*);

### tb/tb_info_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_info_frame_receiver
// Self-checking bench for the framed link receiver. Line bytes are pushed in
// bursts while the result side stalls on its own pattern. A byte-level model
// of the receive state machine predicts every payload byte and reply byte,
// and each popped result is compared field by field with the oldest one
// predicted. Directed frames come first, then a queue-full hold-off, then
// random frames and line noise under several register settings.
// ----------------------------------------------------------------------------
module tb_info_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import ifr_pkg::*;

  localparam int unsigned SETTLE_CYCLES     = 8;
  localparam int unsigned CYCLE_LIMIT       = 300000;
  localparam int unsigned HOLD_OFF_CYCLES   = 250;
  localparam int unsigned ITEMS_PER_SETTING = 55;
  localparam int unsigned NUM_SETTINGS      = 6;
  localparam int unsigned MAX_PRINTED       = 30;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    verdict_e          verdict;
  } line_out_t;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CHECK,
    FR_BAD_ESCAPE,
    FR_ESC_CLOSE,
    FR_NO_CHECK,
    FR_BAD_HEADER
  } frame_fault_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  logic [BYTE_W-1:0]    rx_byte_i   = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic                 out_kind_o;
  logic [BYTE_W-1:0]    out_byte_o;
  logic                 out_last_o;
  logic [1:0]           verdict_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [BYTE_W-1:0]    cfg_wdata_i = '0;

  info_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .empty       (empty),
    .pop         (pop),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .verdict_o   (verdict_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the receiver: register settings and receive state.
  cfg_t line_cfg = {RST_FLAG_BYTE, RST_ESCAPE_BYTE, RST_FLAG_SUBST,
                    RST_ESCAPE_SUBST, RST_CMD_ADDR, RST_REPLY_ADDR};
  phase_e            rx_phase  = PH_WAIT;
  logic              rx_seq    = 1'b0;
  logic [BYTE_W-1:0] run_xor   = '0;
  logic [BYTE_W-1:0] held_byte = '0;
  logic              held_ok   = 1'b0;
  logic              esc_pend  = 1'b0;
  logic              esc_bad   = 1'b0;
  logic              want_seq  = 1'b0;

  line_out_t         awaited_q[$];
  logic [BYTE_W-1:0] line_q[$];
  logic [BYTE_W-1:0] payload_q[$];

  int unsigned err_cnt         = 0;
  int unsigned checked_cnt     = 0;
  int unsigned cycle_cnt       = 0;
  int unsigned pop_hold_cycles = 0;
  int unsigned burst_left      = 0;
  int unsigned gap_cycles      = 1;
  logic        offering        = 1'b0;

  task automatic report_error(input string msg);
    if (err_cnt < MAX_PRINTED) begin
      $display("ERROR at %0t (result %0d): %s", $time, checked_cnt, msg);
    end
    err_cnt++;
  endtask

  task automatic await_out(input kind_e k, input logic [BYTE_W-1:0] d, input logic l,
                           input verdict_e v);
    line_out_t o;
    o.kind    = k;
    o.data    = d;
    o.last    = l;
    o.verdict = v;
    awaited_q.push_back(o);
  endtask

  // Advances the shadow state by one accepted line byte and queues what it yields.
  task automatic step_receiver(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] ctrl;
    logic              take;
    logic              good;
    logic              same_seq;
    verdict_e          v;
    d    = b;
    take = 1'b1;
    case (rx_phase)
      PH_FLAG: begin
        if (b == line_cfg.cmd_addr) rx_phase = PH_ADDR;
        else if (b != line_cfg.flag_byte) rx_phase = PH_WAIT;
      end
      PH_ADDR: begin
        if ((b & ~CTRL_SEQ_BIT) == '0) begin
          rx_seq   = (b & CTRL_SEQ_BIT) != '0;
          rx_phase = PH_CTRL;
        end else begin
          rx_phase = (b == line_cfg.flag_byte) ? PH_FLAG : PH_WAIT;
        end
      end
      PH_CTRL: begin
        if (b == (line_cfg.cmd_addr ^ (rx_seq ? CTRL_SEQ_BIT : 8'h00))) begin
          rx_phase  = PH_DATA;
          run_xor   = '0;
          held_ok   = 1'b0;
          held_byte = '0;
          esc_pend  = 1'b0;
          esc_bad   = 1'b0;
        end else begin
          rx_phase = (b == line_cfg.flag_byte) ? PH_FLAG : PH_WAIT;
        end
      end
      PH_DATA: begin
        if (b == line_cfg.flag_byte) begin
          good     = held_ok && !esc_bad && !esc_pend && (run_xor == held_byte);
          same_seq = (rx_seq == want_seq);
          if (good && same_seq) begin
            v        = VERDICT_ACCEPT;
            want_seq = ~want_seq;
          end else if (same_seq) begin
            v = VERDICT_REJECT;
          end else begin
            v = VERDICT_DISCARD;
          end
          // The reply announces the sequence number wanted next.
          if (v == VERDICT_REJECT) ctrl = want_seq ? CTRL_REJ_SEQ1 : CTRL_REJ_SEQ0;
          else ctrl = want_seq ? CTRL_RR_SEQ1 : CTRL_RR_SEQ0;
          await_out(KIND_REPLY, line_cfg.flag_byte, 1'b0, v);
          await_out(KIND_REPLY, line_cfg.reply_addr, 1'b0, v);
          await_out(KIND_REPLY, ctrl, 1'b0, v);
          await_out(KIND_REPLY, line_cfg.reply_addr ^ ctrl, 1'b0, v);
          await_out(KIND_REPLY, line_cfg.flag_byte, 1'b1, v);
          rx_phase = PH_FLAG;
          held_ok  = 1'b0;
          esc_pend = 1'b0;
          esc_bad  = 1'b0;
          run_xor  = '0;
        end else begin
          if (esc_pend) begin
            esc_pend = 1'b0;
            if (b == line_cfg.flag_subst) d = line_cfg.flag_byte;
            else if (b == line_cfg.escape_subst) d = line_cfg.escape_byte;
            else begin
              esc_bad = 1'b1;
              take    = 1'b0;
            end
          end else if (b == line_cfg.escape_byte) begin
            esc_pend = 1'b1;
            take     = 1'b0;
          end
          // Payload leaves one byte late; the last one before the flag is the check.
          if (take) begin
            if (held_ok) begin
              run_xor ^= held_byte;
              await_out(KIND_PAYLOAD, held_byte, 1'b0, VERDICT_NONE);
            end
            held_byte = d;
            held_ok   = 1'b1;
          end
        end
      end
      default: begin
        rx_phase = (b == line_cfg.flag_byte) ? PH_FLAG : PH_WAIT;
      end
    endcase
  endtask

  // Offers one line byte, holding it until the block takes it.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!offering) begin
      repeat (gap_cycles) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    offering   = 1'b1;
    do @(posedge clk_i); while (full);
    step_receiver(b);
    burst_left--;
    if (burst_left == 0) begin
      push      <= 1'b0;
      offering   = 1'b0;
      gap_cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : 1;
    end
  endtask

  task automatic send_line();
    while (line_q.size() != 0) send_byte(line_q.pop_front());
  endtask

  task automatic stop_offering();
    if (offering) begin
      push      <= 1'b0;
      offering   = 1'b0;
      gap_cycles = 1;
    end
  endtask

  task automatic wait_all_out();
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e r, input logic [BYTE_W-1:0] v);
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
  endtask

  // Called only with the line idle and every result drained.
  task automatic load_settings(input cfg_t c);
    cfg_we_i <= 1'b1;
    put_reg(REG_FLAG_BYTE, c.flag_byte);
    put_reg(REG_ESCAPE_BYTE, c.escape_byte);
    put_reg(REG_FLAG_SUBST, c.flag_subst);
    put_reg(REG_ESCAPE_SUBST, c.escape_subst);
    put_reg(REG_CMD_ADDR, c.cmd_addr);
    put_reg(REG_REPLY_ADDR, c.reply_addr);
    cfg_we_i <= 1'b0;
    line_cfg = c;
  endtask

  // Random payload with a heavy share of delimiter and substitute values.
  task automatic fill_payload(input int unsigned n);
    payload_q.delete();
    repeat (n) begin
      case ($urandom_range(0, 11))
        0:       payload_q.push_back(line_cfg.flag_byte);
        1:       payload_q.push_back(line_cfg.escape_byte);
        2:       payload_q.push_back(line_cfg.flag_subst);
        3:       payload_q.push_back(line_cfg.escape_subst);
        default: payload_q.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic push_stuffed(input logic [BYTE_W-1:0] d);
    if (d == line_cfg.flag_byte) begin
      line_q.push_back(line_cfg.escape_byte);
      line_q.push_back(line_cfg.flag_subst);
    end else if (d == line_cfg.escape_byte) begin
      line_q.push_back(line_cfg.escape_byte);
      line_q.push_back(line_cfg.escape_subst);
    end else begin
      line_q.push_back(d);
    end
  endtask

  task automatic push_bad_escape();
    logic [BYTE_W-1:0] junk;
    do junk = 8'($urandom);
    while (junk == line_cfg.flag_byte || junk == line_cfg.flag_subst ||
           junk == line_cfg.escape_subst);
    line_q.push_back(line_cfg.escape_byte);
    line_q.push_back(junk);
  endtask

  // Builds the line bytes of one information frame around payload_q.
  task automatic compose_frame(input logic seq, input frame_fault_e fault, input int n_open);
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] sum;
    int                bad_at;
    int                n;
    ctrl   = seq ? CTRL_SEQ_BIT : 8'h00;
    sum    = '0;
    n      = payload_q.size();
    bad_at = (fault == FR_BAD_ESCAPE) ? int'($urandom_range(0, n)) : -1;
    repeat (n_open) line_q.push_back(line_cfg.flag_byte);
    if (fault == FR_BAD_HEADER) begin
      case ($urandom_range(0, 2))
        0: begin
          line_q.push_back(line_cfg.cmd_addr ^ 8'($urandom_range(1, 255)));
          line_q.push_back(ctrl);
          line_q.push_back(line_cfg.cmd_addr ^ ctrl);
        end
        1: begin
          line_q.push_back(line_cfg.cmd_addr);
          line_q.push_back(ctrl ^ (8'h01 << $urandom_range(0, 5)));
          line_q.push_back(line_cfg.cmd_addr ^ ctrl);
        end
        default: begin
          line_q.push_back(line_cfg.cmd_addr);
          line_q.push_back(ctrl);
          line_q.push_back(line_cfg.cmd_addr ^ ctrl ^ 8'($urandom_range(1, 255)));
        end
      endcase
    end else begin
      line_q.push_back(line_cfg.cmd_addr);
      line_q.push_back(ctrl);
      line_q.push_back(line_cfg.cmd_addr ^ ctrl);
    end
    if (fault != FR_NO_CHECK) begin
      for (int i = 0; i < n; i++) begin
        if (i == bad_at) push_bad_escape();
        sum ^= payload_q[i];
        push_stuffed(payload_q[i]);
      end
      if (bad_at == n) push_bad_escape();
      push_stuffed((fault == FR_BAD_CHECK) ? sum ^ 8'($urandom_range(1, 255)) : sum);
      if (fault == FR_ESC_CLOSE) line_q.push_back(line_cfg.escape_byte);
    end
    line_q.push_back(line_cfg.flag_byte);
  endtask

  // Result side: random stall pattern plus an optional long hold-off.
  always @(posedge clk_i) begin : result_side
    int unsigned pattern_left;
    int unsigned stall_pct;
    if (pop_hold_cycles > 0) begin
      pop_hold_cycles--;
      pop <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 80);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    line_out_t exp;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end else if (rst_ni && pop && !empty) begin
      if (awaited_q.size() == 0) begin
        report_error($sformatf("unexpected result kind %0d byte %02h", out_kind_o,
                               out_byte_o));
      end else begin
        exp = awaited_q.pop_front();
        if (out_kind_o !== exp.kind)
          report_error($sformatf("kind %0d, want %0d", out_kind_o, exp.kind));
        if (out_byte_o !== exp.data)
          report_error($sformatf("byte %02h, want %02h", out_byte_o, exp.data));
        if (out_last_o !== exp.last)
          report_error($sformatf("last %0d, want %0d", out_last_o, exp.last));
        if (verdict_o !== exp.verdict)
          report_error($sformatf("verdict %0d, want %0d", verdict_o, exp.verdict));
      end
      checked_cnt++;
    end
  end

  // Reset settings: repeated flags, empty payload, duplicate, header
  // mismatch, missing check byte and a stuffed check byte.
  task automatic test_directed_frames();
    line_q.push_back(line_cfg.flag_byte);
    payload_q.delete();
    compose_frame(1'b0, FR_GOOD, 1);
    payload_q = '{8'hFF};
    compose_frame(1'b0, FR_GOOD, 0);
    line_q.push_back(line_cfg.cmd_addr);
    line_q.push_back(CTRL_SEQ_BIT | 8'h01);
    payload_q.delete();
    compose_frame(1'b1, FR_NO_CHECK, 1);
    payload_q = '{8'h00, line_cfg.flag_byte};
    compose_frame(1'b1, FR_GOOD, 0);
    send_line();
    stop_offering();
    wait_all_out();
  endtask

  // The result side holds off while frames keep coming, so the block fills up.
  task automatic test_full_queue_hold_off();
    pop_hold_cycles = HOLD_OFF_CYCLES;
    repeat (5) begin
      fill_payload($urandom_range(4, 8));
      compose_frame(want_seq, FR_GOOD, 1);
      send_line();
    end
    stop_offering();
    wait_all_out();
  endtask

  task automatic test_random_settings();
    cfg_t         c;
    frame_fault_e fault;
    int unsigned  items;
    int unsigned  r;
    logic         seq;
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      case (k)
        0: c = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom)};
        1: c = {8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'h00};
        2: c = {8'hFF, 8'h00, 8'h00, 8'h80, 8'h00, 8'hFF};
        // Flag equal to escape: the flag test wins.
        3: c = {8'hC3, 8'hC3, 8'h3C, 8'h5A, 8'h80, 8'h40};
        // Equal substitutes: an escaped byte always stands for a flag.
        4: c = {8'h7E, 8'h7D, 8'h5E, 8'h5E, 8'h41, 8'h7F};
        default: c = {RST_FLAG_BYTE, RST_ESCAPE_BYTE, RST_FLAG_SUBST, RST_ESCAPE_SUBST,
                      RST_CMD_ADDR, RST_REPLY_ADDR};
      endcase
      stop_offering();
      wait_all_out();
      load_settings(c);
      items = 0;
      while (items < ITEMS_PER_SETTING) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // Line noise between frames.
          repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom));
          items += line_q.size();
          send_line();
        end else begin
          seq = ($urandom_range(0, 4) == 0) ? ~want_seq : want_seq;
          fill_payload(($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                   : $urandom_range(0, 6));
          fault = (r < 72) ? FR_GOOD : frame_fault_e'($urandom_range(1, 5));
          compose_frame(seq, fault, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2));
          items += line_q.size();
          send_line();
          if ($urandom_range(0, 19) == 0) begin
            stop_offering();
            wait_all_out();
          end
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_full_queue_hold_off();
    test_random_settings();
    stop_offering();
    wait_all_out();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
